// ===== design/assert_macros.svh =====
// Assertion macros used by the calibration sequencer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define TCC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that an antecedent implies a consequent at the same edge.
`define TCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/tcc_pkg.sv =====
// Types, constants and helper functions of the touch corner calibration sequencer.
package tcc_pkg;

    localparam int RAW_W    = 16;
    localparam int SIZE_W   = 12;
    localparam int STEP_W   = 3;
    localparam int CNT_W    = $clog2(RAW_W);

    localparam logic [SIZE_W-1:0] CAL_OFFSET = SIZE_W'(30);

    localparam logic [STEP_W-1:0] STEP_LT     = 3'd0;
    localparam logic [STEP_W-1:0] STEP_RT     = 3'd1;
    localparam logic [STEP_W-1:0] STEP_RB     = 3'd2;
    localparam logic [STEP_W-1:0] STEP_LB     = 3'd3;
    localparam logic [STEP_W-1:0] STEP_CENTRE = 3'd4;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(800);
    localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(480);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_MAR,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [RAW_W-1:0] avg16(input logic [RAW_W-1:0] a,
                                               input logic [RAW_W-1:0] b);
        logic [RAW_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[RAW_W:1];
    endfunction

    function automatic logic [RAW_W-1:0] times15(input logic [RAW_W-1:0] q);
        return {q[RAW_W-5:0], 4'b0000} - q;
    endfunction

endpackage

// ===== design/touch_corner_calibration_sequencer.sv =====
// Top level of the touch corner calibration sequencer.
// Usage: one transfer on the s_axis channel carries one raw touch reading
// (raw_x, raw_y) for the target currently shown. Each accepted reading yields
// exactly one result transfer on the m_axis channel with the new target index,
// the four raw edge values and a done flag in tuser. The targets run
// left-top, right-top, right-bottom, left-bottom, centre and then start over.
// A corner reading passes through the calculation state, which registers the
// result once the output is free, and the block then returns to idle. The
// centre reading also starts the two bit-serial dividers that compute the
// horizontal and vertical margins one quotient bit per cycle, then passes the
// margin and finish states before it returns to idle.
// One reading is processed at a time; s_axis_tready is high while the block
// waits for a reading, also while an earlier result still waits on m_axis.
// When m_axis_tready is low the finished result holds, and a newly accepted
// reading is held back until that result is taken. The screen size registers
// are to be written on the configuration port only while the block is idle;
// the block itself does not enforce this. Reset clears the sequence to the
// left-top target, zeroes all edges and loads a screen size of 800 by 480.
`include "assert_macros.svh"

module touch_corner_calibration_sequencer
    import tcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [15:0] raw_x, [31:16] raw_y
    input  logic [31:0]       s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [2:0] next_target, [18:3] left_raw, [34:19] right_raw,
    // [50:35] top_raw, [66:51] bottom_raw, [71:67] zero
    output logic [71:0]       m_axis_tdata,
    // [0] done_res
    output logic              m_axis_tuser
);

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [RAW_W-1:0]  r_left;
    logic [RAW_W-1:0]  r_right;
    logic [RAW_W-1:0]  r_top;
    logic [RAW_W-1:0]  r_bottom;
    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;
    logic [RAW_W-1:0]  r_x;
    logic [RAW_W-1:0]  r_y;
    logic [RAW_W-1:0]  r_mx;
    logic [RAW_W-1:0]  r_my;
    logic              r_x_fwd;
    logic              r_y_fwd;
    logic              r_x_zero;
    logic              r_y_zero;
    logic              r_out_valid;
    logic              r_out_done;

    logic              w_accept;
    logic              w_out_free;
    logic              w_load;
    logic              w_div_start;
    logic              w_centre;
    logic              w_x_fwd;
    logic              w_y_fwd;
    logic [RAW_W-1:0]  w_span_x;
    logic [RAW_W-1:0]  w_span_y;
    logic [SIZE_W-1:0] w_dvs_x;
    logic [SIZE_W-1:0] w_dvs_y;
    t_div_stat         w_stat_x;
    t_div_stat         w_stat_y;
    logic [RAW_W-1:0]  w_quot_x;
    logic [RAW_W-1:0]  w_quot_y;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_centre   = (r_step == STEP_CENTRE);
    assign w_x_fwd    = (r_right > r_left);
    assign w_y_fwd    = (r_bottom > r_top);
    assign w_span_x   = w_x_fwd ? (r_right - r_left) : (r_left - r_right);
    assign w_span_y   = w_y_fwd ? (r_bottom - r_top) : (r_top - r_bottom);
    assign w_dvs_x    = r_width - CAL_OFFSET;
    assign w_dvs_y    = r_height - CAL_OFFSET;

    tcc_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_span_x),
        .i_divisor  (w_dvs_x),
        .o_stat     (w_stat_x),
        .o_quot     (w_quot_x)
    );

    tcc_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_span_y),
        .i_divisor  (w_dvs_y),
        .o_stat     (w_stat_y),
        .o_quot     (w_quot_y)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_CALC;
            end
            ST_CALC: begin
                if (w_centre) n_state = ST_DIV;
                else if (w_out_free) n_state = ST_IDLE;
            end
            ST_DIV: begin
                if (w_stat_x.done) n_state = ST_MAR;
            end
            ST_MAR: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_div_start   = 1'b0;
        w_load        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_CALC: begin
                w_div_start = w_centre;
                w_load      = !w_centre && w_out_free;
            end
            ST_FIN: begin
                w_load = w_out_free;
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_LT;
            r_left      <= '0;
            r_right     <= '0;
            r_top       <= '0;
            r_bottom    <= '0;
            r_width     <= WIDTH_RST;
            r_height    <= HEIGHT_RST;
            r_out_valid <= 1'b0;
            r_out_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_WIDTH) r_width <= i_cfg_data;
                if (i_cfg_addr == CFG_HEIGHT) r_height <= i_cfg_data;
            end
            r_out_valid <= w_load || (r_out_valid && !m_axis_tready);
            if (w_load) begin
                if (r_state == ST_FIN) begin
                    r_out_done <= 1'b1;
                    r_step     <= STEP_LT;
                    r_left     <= r_x_fwd ? (r_left - r_mx) : (r_left + r_mx);
                    r_right    <= r_x_fwd ? (r_right + r_mx) : (r_right - r_mx);
                    r_top      <= r_y_fwd ? (r_top - r_my) : (r_top + r_my);
                    r_bottom   <= r_y_fwd ? (r_bottom + r_my) : (r_bottom - r_my);
                end else begin
                    r_out_done <= 1'b0;
                    case (r_step)
                        STEP_RT: begin
                            r_step  <= STEP_RB;
                            r_right <= r_x;
                            r_top   <= avg16(r_top, r_y);
                        end
                        STEP_RB: begin
                            r_step   <= STEP_LB;
                            r_right  <= avg16(r_right, r_x);
                            r_bottom <= r_y;
                        end
                        STEP_LB: begin
                            r_step   <= STEP_CENTRE;
                            r_left   <= avg16(r_left, r_x);
                            r_bottom <= avg16(r_bottom, r_y);
                        end
                        default: begin
                            r_step <= STEP_RT;
                            r_left <= r_x;
                            r_top  <= r_y;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x <= s_axis_tdata[15:0];
            r_y <= s_axis_tdata[31:16];
        end
        if (w_div_start) begin
            r_x_fwd  <= w_x_fwd;
            r_y_fwd  <= w_y_fwd;
            r_x_zero <= (r_width <= CAL_OFFSET);
            r_y_zero <= (r_height <= CAL_OFFSET);
        end
        if (r_state == ST_MAR) begin
            r_mx <= r_x_zero ? '0 : times15(w_quot_x);
            r_my <= r_y_zero ? '0 : times15(w_quot_y);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_done;
    assign m_axis_tdata  = {5'b00000, r_bottom, r_top, r_right, r_left, r_step};

    `TCC_ASSERT(a_div_lockstep, i_clk, i_rst_n, w_stat_x.busy == w_stat_y.busy,
        "Margin dividers are out of step.")
    `TCC_ASSERT_IMP(a_div_from_calc, i_clk, i_rst_n, $rose(w_stat_x.busy),
        $past(r_state) == ST_CALC, "Divider started outside the calculation state.")
    `TCC_ASSERT_IMP(a_done_restarts, i_clk, i_rst_n, r_out_valid && r_out_done,
        r_step == STEP_LT, "Finished calibration did not return to the first target.")
    `TCC_ASSERT(a_step_range, i_clk, i_rst_n, r_step <= STEP_CENTRE,
        "Target step left the valid range.")

endmodule

// ===== design/tcc_div.sv =====
// Restoring bit-serial divider producing one quotient bit per cycle.
module tcc_div
    import tcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAW_W-1:0]  i_dividend,
    input  logic [SIZE_W-1:0] i_divisor,
    output t_div_stat         o_stat,
    output logic [RAW_W-1:0]  o_quot
);

    logic [RAW_W-1:0]  r_quot;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [SIZE_W:0]   w_trial;
    logic [SIZE_W:0]   w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_quot[RAW_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(RAW_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(RAW_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[RAW_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[SIZE_W-1:0] : w_trial[SIZE_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

// ===== tb/sv/calibration_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts each calibration result from the accepted touches and compares it.
module calibration_checker
    import tcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    // [15:0] raw_x, [31:16] raw_y
    input  logic [31:0]       s_axis_tdata,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [2:0] next_target, [18:3] left_raw, [34:19] right_raw,
    // [50:35] top_raw, [66:51] bottom_raw, [71:67] zero
    input  logic [71:0]       m_axis_tdata,
    // [0] done_res
    input  logic              m_axis_tuser,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_results_checked
);

    localparam int MARGIN_SCALE = 15;
    localparam int PRINT_LIMIT  = 30;

    typedef struct packed {
        logic              done;
        logic [STEP_W-1:0] target;
        logic [RAW_W-1:0]  left;
        logic [RAW_W-1:0]  right;
        logic [RAW_W-1:0]  top;
        logic [RAW_W-1:0]  bottom;
    } t_cal_result;

    logic [SIZE_W-1:0] width_px;
    logic [SIZE_W-1:0] height_px;
    logic [STEP_W-1:0] step;
    logic [RAW_W-1:0]  left_edge;
    logic [RAW_W-1:0]  right_edge;
    logic [RAW_W-1:0]  top_edge;
    logic [RAW_W-1:0]  bottom_edge;
    t_cal_result       expected_q[$];
    int                mismatches = 0;
    int                checked = 0;

    function automatic logic [RAW_W-1:0] halved_sum(input logic [RAW_W-1:0] a,
                                                    input logic [RAW_W-1:0] b);
        return RAW_W'((int'(a) + int'(b)) / 2);
    endfunction

    function automatic logic [RAW_W-1:0] edge_margin(input logic [RAW_W-1:0] a,
                                                     input logic [RAW_W-1:0] b,
                                                     input logic [SIZE_W-1:0] size);
        int span;
        if (size <= CAL_OFFSET) begin
            return '0;
        end
        span = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        return RAW_W'((span / (int'(size) - int'(CAL_OFFSET))) * MARGIN_SCALE);
    endfunction

    // Returns {hi, lo} pushed apart by the margin, mirrored for an inverted axis.
    function automatic logic [2*RAW_W-1:0] widened(input logic [RAW_W-1:0] lo,
                                                   input logic [RAW_W-1:0] hi,
                                                   input logic [RAW_W-1:0] m);
        if (hi > lo) begin
            return {RAW_W'(hi + m), RAW_W'(lo - m)};
        end else begin
            return {RAW_W'(hi - m), RAW_W'(lo + m)};
        end
    endfunction

    function automatic t_cal_result apply_touch(input logic [RAW_W-1:0] x,
                                                input logic [RAW_W-1:0] y);
        t_cal_result       r;
        logic [STEP_W-1:0] cur;
        logic [RAW_W-1:0]  mx;
        logic [RAW_W-1:0]  my;
        r.done = 1'b0;
        cur = (step > STEP_CENTRE) ? STEP_LT : step;
        case (cur)
            STEP_RT: begin
                right_edge = x;
                top_edge = halved_sum(top_edge, y);
            end
            STEP_RB: begin
                right_edge = halved_sum(right_edge, x);
                bottom_edge = y;
            end
            STEP_LB: begin
                left_edge = halved_sum(left_edge, x);
                bottom_edge = halved_sum(bottom_edge, y);
            end
            STEP_CENTRE: begin
                mx = edge_margin(left_edge, right_edge, width_px);
                my = edge_margin(top_edge, bottom_edge, height_px);
                {right_edge, left_edge} = widened(left_edge, right_edge, mx);
                {bottom_edge, top_edge} = widened(top_edge, bottom_edge, my);
                r.done = 1'b1;
            end
            default: begin
                left_edge = x;
                top_edge = y;
            end
        endcase
        step = r.done ? STEP_LT : cur + 1'b1;
        r.target = step;
        r.left = left_edge;
        r.right = right_edge;
        r.top = top_edge;
        r.bottom = bottom_edge;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
    endtask

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_cal_result want;
        t_cal_result got;
        if (!i_rst_n) begin
            width_px = WIDTH_RST;
            height_px = HEIGHT_RST;
            step = STEP_LT;
            left_edge = '0;
            right_edge = '0;
            top_edge = '0;
            bottom_edge = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_WIDTH) begin
                    width_px = i_cfg_data;
                end else begin
                    height_px = i_cfg_data;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.done = m_axis_tuser;
                got.target = m_axis_tdata[2:0];
                got.left = m_axis_tdata[18:3];
                got.right = m_axis_tdata[34:19];
                got.top = m_axis_tdata[50:35];
                got.bottom = m_axis_tdata[66:51];
                if (expected_q.size() == 0) begin
                    report_mismatch("result with none outstanding", m_axis_tdata[31:0], '0);
                end else begin
                    want = expected_q.pop_front();
                    compare_field("done_res", 32'(got.done), 32'(want.done));
                    compare_field("next_target", 32'(got.target), 32'(want.target));
                    compare_field("left_raw", 32'(got.left), 32'(want.left));
                    compare_field("right_raw", 32'(got.right), 32'(want.right));
                    compare_field("top_raw", 32'(got.top), 32'(want.top));
                    compare_field("bottom_raw", 32'(got.bottom), 32'(want.bottom));
                    compare_field("tdata padding", 32'(m_axis_tdata[71:67]), '0);
                end
                checked++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_q.push_back(apply_touch(s_axis_tdata[15:0], s_axis_tdata[31:16]));
            end
        end
        o_pending <= expected_q.size();
        o_fail_count <= mismatches;
        o_results_checked <= checked;
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the calibration sequencer testbench: clock, reset, stimulus and verdict.
module testbench;
    import tcc_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RUNS_PER_PHASE = 50;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_addr = CFG_WIDTH;
    logic [SIZE_W-1:0] i_cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [71:0]       m_axis_tdata;
    logic              m_axis_tuser;

    int   fail_count;
    int   results_pending;
    int   results_checked;
    int   sender_idle_pct = 8;
    int   sink_idle_pct = 77;
    logic hold_go = 1'b0;
    int   touches_sent = 0;
    int   settings_tried = 0;

    touch_corner_calibration_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    calibration_checker cal_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .m_axis_tuser      (m_axis_tuser),
        .o_fail_count      (fail_count),
        .o_pending         (results_pending),
        .o_results_checked (results_checked)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("touch_corner_calibration_sequencer test failed");
        $finish;
    end

    // The result side: random back-pressure plus one long stall on request.
    initial begin : result_sink
        int   held;
        logic hold_taken;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_taken) begin
                hold_taken = 1'b1;
                m_axis_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) begin
                    @(posedge i_clk);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_touch(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        touches_sent++;
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
    endtask

    task automatic set_screen(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        wait_for_results();
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_addr <= CFG_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_tried++;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(9))
            0: return SIZE_W'($urandom_range(30));
            1: return SIZE_W'(4095);
            2: return SIZE_W'(31);
            default: return SIZE_W'($urandom_range(4095, 31));
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_extreme();
        case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            default: return 16'h7FFF;
        endcase
    endfunction

    // One full pass of five touches: mostly plausible corners with jitter, some noise.
    task automatic run_calibration();
        logic [RAW_W-1:0] lo_x;
        logic [RAW_W-1:0] hi_x;
        logic [RAW_W-1:0] lo_y;
        logic [RAW_W-1:0] hi_y;
        logic [RAW_W-1:0] x;
        logic [RAW_W-1:0] y;
        int               style;
        int               k;
        style = $urandom_range(9);
        lo_x = RAW_W'($urandom_range(20000));
        hi_x = 16'hFFFF - RAW_W'($urandom_range(20000));
        lo_y = RAW_W'($urandom_range(20000));
        hi_y = 16'hFFFF - RAW_W'($urandom_range(20000));
        if ($urandom_range(1)) begin
            {lo_x, hi_x} = {hi_x, lo_x};
        end
        if ($urandom_range(1)) begin
            {lo_y, hi_y} = {hi_y, lo_y};
        end
        for (k = 0; k < 5; k++) begin
            x = (k == 1 || k == 2) ? hi_x : lo_x;
            y = (k == 2 || k == 3) ? hi_y : lo_y;
            case (style)
                6, 7: begin
                    x = RAW_W'($urandom);
                    y = RAW_W'($urandom);
                end
                8: begin
                    x = pick_extreme();
                    y = pick_extreme();
                end
                9: begin
                    x = lo_x;
                    y = lo_y;
                end
                default: begin
                    x = x ^ RAW_W'($urandom_range(255));
                    y = y ^ RAW_W'($urandom_range(255));
                    if (k == 4) begin
                        x = RAW_W'($urandom);
                        y = RAW_W'($urandom);
                    end
                end
            endcase
            send_touch(x, y);
        end
    endtask

    initial begin : stimulus
        int phase;
        int run;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default screen, upright axes, then both axes inverted at the field limits.
        send_touch(16'd200, 16'd300);
        send_touch(16'd3800, 16'd320);
        send_touch(16'd3790, 16'd3700);
        send_touch(16'd210, 16'd3710);
        send_touch(16'd2000, 16'd2000);
        send_touch(16'hFFFF, 16'hFFFF);
        send_touch(16'h0000, 16'h0000);
        send_touch(16'h0000, 16'h0000);
        send_touch(16'hFFFF, 16'hFFFF);
        send_touch(16'h0000, 16'hFFFF);

        // Screens too small for a divisor get no margin on that axis.
        set_screen(SIZE_W'(30), SIZE_W'(0));
        send_touch(16'd1000, 16'd1000);
        send_touch(16'd60000, 16'd2000);
        send_touch(16'd61000, 16'd62000);
        send_touch(16'd900, 16'd63000);
        send_touch(16'hFFFF, 16'h0000);

        // A divisor of one makes the margin wrap.
        set_screen(SIZE_W'(31), SIZE_W'(4095));
        send_touch(16'h0000, 16'h0000);
        send_touch(16'hFFFF, 16'd40000);
        send_touch(16'hFFFF, 16'hFFFF);
        send_touch(16'h0000, 16'hFFFF);
        send_touch(16'd1234, 16'd5678);

        for (phase = 0; phase < 3; phase++) begin
            for (run = 0; run < RUNS_PER_PHASE; run++) begin
                if (run == 0 || $urandom_range(7) == 0) begin
                    set_screen(pick_size(), pick_size());
                end
                if (run == 0) begin
                    sender_idle_pct <= (phase == 0) ? 8 : (phase == 1) ? 77 : 0;
                    sink_idle_pct <= (phase == 0) ? 77 : (phase == 1) ? 8 : 0;
                end
                if (phase == 0 && run == 20) begin
                    hold_go <= 1'b1;
                end
                run_calibration();
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Summary: %0d touches in %0d calibration passes over %0d screen settings, ",
                 touches_sent, touches_sent / 5, settings_tried,
                 "including sizes too small for a margin and the full 4095.");
        $display("Summary: %0d results compared under input-heavy, output-heavy and no idling, ",
                 results_checked, "with one %0d-cycle output stall.", HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("touch_corner_calibration_sequencer test passed");
        end else begin
            $display("touch_corner_calibration_sequencer test failed");
        end
        $finish;
    end

endmodule
